// ===== design/cca_pkg.sv =====
// Shared types, constants and calendar tables for the cron calendar alarm matcher.
`timescale 1ns / 1ps

package cca_pkg;

    // Rule table size and the index/counter widths derived from it
    localparam int RULE_COUNT = 16;
    localparam int RIDX_W     = (RULE_COUNT > 1) ? $clog2(RULE_COUNT) : 1;
    localparam int RCNT_W     = $clog2(RULE_COUNT + 1);

    // Request kinds carried on the input tuser
    localparam logic [1:0] REQ_LOAD = 2'd0;
    localparam logic [1:0] REQ_SET  = 2'd1;
    localparam logic [1:0] REQ_TICK = 2'd2;

    // Calendar limits
    localparam logic [13:0] YEAR_MIN = 14'd1970;
    localparam logic [13:0] YEAR_MAX = 14'd9999;

    // One rule: five match masks, minute mask in the top bits
    typedef struct packed {
        logic [59:0] minute;
        logic [23:0] hour;
        logic [30:0] day;
        logic [11:0] month;
        logic [6:0]  weekday;
    } t_rule;

    // Current calendar time
    typedef struct packed {
        logic [13:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [2:0]  weekday;
    } t_time;

    // Raw date and time of a set item
    typedef struct packed {
        logic [13:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
    } t_set;

    // Days in month m (1..12), with the leap-year February
    function automatic logic [4:0] days_in(input logic [3:0] m, input logic leap);
        logic [4:0] d;
        case (m)
            4'd2:                      d = leap ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:   d = 5'd30;
            default:                   d = 5'd31;
        endcase
        return d;
    endfunction

    // Days of the year before the first of month m, common year
    function automatic logic [8:0] days_before(input logic [3:0] m);
        logic [8:0] d;
        case (m)
            4'd2:    d = 9'd31;
            4'd3:    d = 9'd59;
            4'd4:    d = 9'd90;
            4'd5:    d = 9'd120;
            4'd6:    d = 9'd151;
            4'd7:    d = 9'd181;
            4'd8:    d = 9'd212;
            4'd9:    d = 9'd243;
            4'd10:   d = 9'd273;
            4'd11:   d = 9'd304;
            4'd12:   d = 9'd334;
            default: d = 9'd0;
        endcase
        return d;
    endfunction

endpackage

// ===== design/cca_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps

module cca_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                     i_clk,
    input  logic                                     i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                         i_wdata,
    input  logic                                     i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port, data holds while not enabled
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/cca_clock.sv =====
// Calendar clock: time registers, set sequence with weekday unit, minute advance.
`timescale 1ns / 1ps

module cca_clock
    import cca_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_set_vld,
    input  t_set  i_set,
    input  logic  i_adv,
    output t_time o_time,
    output logic  o_busy
);

    typedef enum logic [5:0] {
        CK_IDLE = 6'b000001,
        CK_Q1   = 6'b000010,
        CK_Q2   = 6'b000100,
        CK_DAY  = 6'b001000,
        CK_MOD  = 6'b010000,
        CK_WDAY = 6'b100000
    } t_ck_state;

    t_ck_state   r_state;
    logic [13:0] r_year;
    logic [3:0]  r_month;
    logic [4:0]  r_day;
    logic [4:0]  r_hour;
    logic [5:0]  r_minute;
    logic [2:0]  r_wday;
    // year mod 4, year mod 100, century mod 4: leap-year state
    logic [1:0]  r_ymod4;
    logic [6:0]  r_ymod100;
    logic [1:0]  r_cmod4;
    // weekday unit work registers
    logic [6:0]  r_q100;
    logic [11:0] r_q7;
    logic [13:0] r_acc;

    // x / 100 for x below 12800 by reciprocal multiply
    function automatic logic [6:0] div100(input logic [13:0] x);
        logic [26:0] p;
        p = 27'(x) * 27'd5243;
        return p[25:19];
    endfunction

    // x / 7 for x below 16384 by reciprocal multiply
    function automatic logic [11:0] div7(input logic [13:0] x);
        logic [28:0] p;
        p = 29'(x) * 29'd18725;
        return p[28:17];
    endfunction

    logic        leap;
    logic [4:0]  dim;
    logic [13:0] set_year;
    logic [3:0]  set_month;
    logic [4:0]  set_hour;
    logic [5:0]  set_minute;
    logic [4:0]  day_sat;
    logic [13:0] leaps_since;
    logic [13:0] day_sum;
    logic [13:0] q100_x100;
    logic [14:0] q7_x7;
    logic [13:0] year_m1;

    assign leap = ((r_ymod4 == 2'd0) && (r_ymod100 != 7'd0)) ||
                  ((r_ymod100 == 7'd0) && (r_cmod4 == 2'd0));
    assign dim  = days_in(r_month, leap);

    // Saturate the set year, month, hour and minute into range
    always_comb begin
        if (i_set.year < YEAR_MIN) begin
            set_year = YEAR_MIN;
        end else if (i_set.year > YEAR_MAX) begin
            set_year = YEAR_MAX;
        end else begin
            set_year = i_set.year;
        end
        if (i_set.month == 4'd0) begin
            set_month = 4'd1;
        end else if (i_set.month > 4'd12) begin
            set_month = 4'd12;
        end else begin
            set_month = i_set.month;
        end
        set_hour   = (i_set.hour > 5'd23) ? 5'd23 : i_set.hour;
        set_minute = (i_set.minute > 6'd59) ? 6'd59 : i_set.minute;
    end

    // Day clamp, and a sum congruent mod 7 to the day count since 1970-01-01 plus the Thursday offset
    always_comb begin
        if (r_day == 5'd0) begin
            day_sat = 5'd1;
        end else if (r_day > dim) begin
            day_sat = dim;
        end else begin
            day_sat = r_day;
        end
        year_m1     = r_year - 14'd1;
        // leap years in 1970..year-1; r_q100 holds (year-1)/100 here
        leaps_since = (year_m1 >> 2) - 14'(r_q100) + 14'(r_q100[6:2]) - 14'd477;
        day_sum     = (r_year - YEAR_MIN) + leaps_since + 14'(days_before(r_month))
                    + 14'((r_month > 4'd2) && leap) + 14'(day_sat) - 14'd1 + 14'd4;
        q100_x100   = 14'(r_q100) * 14'd100;
        q7_x7       = 15'(r_q7) * 15'd7;
    end

    // Minute advance with carries, holding at the end of the calendar
    logic [13:0] n_year;
    logic [3:0]  n_month;
    logic [4:0]  n_day;
    logic [4:0]  n_hour;
    logic [5:0]  n_minute;
    logic [2:0]  n_wday;
    logic [1:0]  n_ymod4;
    logic [6:0]  n_ymod100;
    logic [1:0]  n_cmod4;
    logic        end_cal;

    assign end_cal = (r_year == YEAR_MAX) && (r_month == 4'd12) && (r_day == 5'd31) &&
                     (r_hour == 5'd23) && (r_minute == 6'd59);

    always_comb begin
        n_year    = r_year;
        n_month   = r_month;
        n_day     = r_day;
        n_hour    = r_hour;
        n_minute  = r_minute;
        n_wday    = r_wday;
        n_ymod4   = r_ymod4;
        n_ymod100 = r_ymod100;
        n_cmod4   = r_cmod4;
        if (!end_cal) begin
            if (r_minute != 6'd59) begin
                n_minute = r_minute + 6'd1;
            end else begin
                n_minute = 6'd0;
                if (r_hour != 5'd23) begin
                    n_hour = r_hour + 5'd1;
                end else begin
                    n_hour = 5'd0;
                    n_wday = (r_wday == 3'd6) ? 3'd0 : r_wday + 3'd1;
                    if (r_day != dim) begin
                        n_day = r_day + 5'd1;
                    end else begin
                        n_day = 5'd1;
                        if (r_month != 4'd12) begin
                            n_month = r_month + 4'd1;
                        end else begin
                            n_month = 4'd1;
                            n_year  = r_year + 14'd1;
                            n_ymod4 = r_ymod4 + 2'd1;
                            if (r_ymod100 == 7'd99) begin
                                n_ymod100 = 7'd0;
                                n_cmod4   = r_cmod4 + 2'd1;
                            end else begin
                                n_ymod100 = r_ymod100 + 7'd1;
                            end
                        end
                    end
                end
            end
        end
    end

    // Set sequence and advance
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= CK_IDLE;
            r_year    <= YEAR_MIN;
            r_month   <= 4'd1;
            r_day     <= 5'd1;
            r_hour    <= 5'd0;
            r_minute  <= 6'd0;
            r_wday    <= 3'd4;
            r_ymod4   <= 2'd2;
            r_ymod100 <= 7'd70;
            r_cmod4   <= 2'd3;
        end else begin
            case (r_state)
                CK_IDLE: begin
                    if (i_set_vld) begin
                        r_year   <= set_year;
                        r_month  <= set_month;
                        r_day    <= i_set.day;
                        r_hour   <= set_hour;
                        r_minute <= set_minute;
                        r_state  <= CK_Q1;
                    end else if (i_adv) begin
                        r_year    <= n_year;
                        r_month   <= n_month;
                        r_day     <= n_day;
                        r_hour    <= n_hour;
                        r_minute  <= n_minute;
                        r_wday    <= n_wday;
                        r_ymod4   <= n_ymod4;
                        r_ymod100 <= n_ymod100;
                        r_cmod4   <= n_cmod4;
                    end
                end
                CK_Q1: begin
                    r_state <= CK_Q2;
                end
                CK_Q2: begin
                    r_ymod100 <= 7'(r_year - q100_x100);
                    r_cmod4   <= r_q100[1:0];
                    r_ymod4   <= r_year[1:0];
                    r_state   <= CK_DAY;
                end
                CK_DAY: begin
                    r_day   <= day_sat;
                    r_state <= CK_MOD;
                end
                CK_MOD: begin
                    r_state <= CK_WDAY;
                end
                CK_WDAY: begin
                    r_wday  <= 3'(15'(r_acc) - q7_x7);
                    r_state <= CK_IDLE;
                end
                default: begin
                    r_state <= CK_IDLE;
                end
            endcase
        end
    end

    // Weekday unit datapath: one multiply per cycle
    always_ff @(posedge i_clk) begin
        case (r_state)
            CK_Q1:   r_q100 <= div100(r_year);
            CK_Q2:   r_q100 <= div100(year_m1);
            CK_DAY:  r_acc  <= day_sum;
            CK_MOD:  r_q7   <= div7(r_acc);
            default: r_q100 <= r_q100;
        endcase
    end

    assign o_time = '{year: r_year, month: r_month, day: r_day,
                      hour: r_hour, minute: r_minute, weekday: r_wday};
    assign o_busy = (r_state != CK_IDLE);

endmodule

// ===== design/cron_calendar_alarm_matcher.sv =====
// Top level: rule table, tick scan over the table, result output register.
`timescale 1ns / 1ps

// Cron rule matcher on a calendar clock. The item kind is on s_tuser: a load
// item writes one rule (five masks) into the rule RAM; a set item loads the
// date and time and keeps the input busy while the weekday is computed step
// by step by the weekday unit; a tick item scans the rule RAM one rule per cycle
// through its single read port while the output does not stall. Each matching
// rule gives one result, and a tick with no match gives one result with hit
// (m_tuser) clear; tlast marks the final result of the tick. A hit waits in a
// pending register and then in an output register, so backpressure on the output
// only stalls the scan when a new hit comes while both are full. The clock
// then advances one minute and holds at 9999-12-31 23:59.
module cron_calendar_alarm_matcher
    import cca_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    // rule_index, minute_mask, hour_mask, day_mask, month_mask, weekday_mask,
    // set_year, set_month, set_day, set_hour, set_minute, 4 zero bits
    input  logic [175:0] i_s_tdata,
    // req_type
    input  logic [1:0]   i_s_tuser,
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    // matched_rule, out_year, out_month, out_day, out_hour, out_minute,
    // out_weekday, 7 zero bits
    output logic [47:0]  o_m_tdata,
    // hit
    output logic         o_m_tuser,
    // last
    output logic         o_m_tlast
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_FIN  = 3'b100
    } t_state;

    t_state              r_state;
    logic [RULE_COUNT-1:0] r_rule_vld;
    logic [RCNT_W-1:0]   r_rd_idx;
    logic                r_ev_vld;
    logic [RIDX_W-1:0]   r_ev_idx;
    logic                r_pend_vld;
    logic [RIDX_W-1:0]   r_pend_rule;
    logic                r_out_vld;
    logic                r_out_hit;
    logic [3:0]          r_out_rule;
    logic                r_out_last;
    t_time               r_out_time;

    // Input unpacking
    logic [3:0] in_rule_index;
    t_rule      in_rule;
    t_set       in_set;

    assign in_rule_index   = i_s_tdata[3:0];
    assign in_rule.minute  = i_s_tdata[63:4];
    assign in_rule.hour    = i_s_tdata[87:64];
    assign in_rule.day     = i_s_tdata[118:88];
    assign in_rule.month   = i_s_tdata[130:119];
    assign in_rule.weekday = i_s_tdata[137:131];
    assign in_set.year     = i_s_tdata[151:138];
    assign in_set.month    = i_s_tdata[155:152];
    assign in_set.day      = i_s_tdata[160:156];
    assign in_set.hour     = i_s_tdata[165:161];
    assign in_set.minute   = i_s_tdata[171:166];

    // Clock
    t_time cur;
    logic  clk_busy;
    logic  accept;
    logic  set_vld;
    logic  adv;

    assign o_s_tready = (r_state == ST_IDLE) && !clk_busy;
    assign accept     = i_s_tvalid && o_s_tready;
    assign set_vld    = accept && (i_s_tuser == REQ_SET);

    cca_clock u_clock (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_set_vld (set_vld),
        .i_set     (in_set),
        .i_adv     (adv),
        .o_time    (cur),
        .o_busy    (clk_busy)
    );

    // Rule RAM
    logic  load_we;
    logic  ram_re;
    t_rule ram_rdata;

    assign load_we = accept && (i_s_tuser == REQ_LOAD) &&
                     (32'(in_rule_index) < RULE_COUNT);

    cca_ram #(
        .WIDTH ($bits(t_rule)),
        .DEPTH (RULE_COUNT)
    ) u_rules (
        .i_clk   (i_clk),
        .i_we    (load_we),
        .i_waddr (RIDX_W'(in_rule_index)),
        .i_wdata (in_rule),
        .i_re    (ram_re),
        .i_raddr (r_rd_idx[RIDX_W-1:0]),
        .o_rdata (ram_rdata)
    );

    // Match of the rule in the read register against the current time
    logic [4:0] day_bit;
    logic [3:0] month_bit;
    logic       ev_hit;
    logic       rd_more;
    logic       out_free;
    logic       push_mid;
    logic       stall;
    logic       push_fin;

    assign day_bit   = cur.day - 5'd1;
    assign month_bit = cur.month - 4'd1;
    assign ev_hit    = r_ev_vld && r_rule_vld[r_ev_idx] &&
                       ram_rdata.minute[cur.minute] && ram_rdata.hour[cur.hour] &&
                       ram_rdata.day[day_bit] && ram_rdata.month[month_bit] &&
                       ram_rdata.weekday[cur.weekday];
    assign rd_more   = (r_state == ST_SCAN) && (r_rd_idx < RCNT_W'(RULE_COUNT));
    assign out_free  = !r_out_vld || i_m_tready;
    // a new hit releases the held one, which is then known not to be last
    assign push_mid  = (r_state == ST_SCAN) && ev_hit && r_pend_vld;
    assign stall     = push_mid && !out_free;
    assign ram_re    = rd_more && !stall;
    assign push_fin  = (r_state == ST_FIN) && out_free;
    assign adv       = push_fin;

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_rule_vld <= '0;
            r_rd_idx   <= '0;
            r_ev_vld   <= 1'b0;
            r_pend_vld <= 1'b0;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (load_we) begin
                        r_rule_vld[RIDX_W'(in_rule_index)] <= 1'b1;
                    end
                    if (accept && (i_s_tuser == REQ_TICK)) begin
                        r_rd_idx   <= '0;
                        r_ev_vld   <= 1'b0;
                        r_pend_vld <= 1'b0;
                        r_state    <= ST_SCAN;
                    end
                end
                ST_SCAN: begin
                    if (!stall) begin
                        r_ev_vld <= rd_more;
                        if (rd_more) begin
                            r_rd_idx <= r_rd_idx + RCNT_W'(1);
                        end else begin
                            r_state <= ST_FIN;
                        end
                        if (ev_hit) begin
                            r_pend_vld <= 1'b1;
                        end
                    end
                end
                ST_FIN: begin
                    if (out_free) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // Scan payload
    always_ff @(posedge i_clk) begin
        if ((r_state == ST_SCAN) && !stall) begin
            r_ev_idx <= r_rd_idx[RIDX_W-1:0];
            if (ev_hit) begin
                r_pend_rule <= r_ev_idx;
            end
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if ((push_mid && out_free) || push_fin) begin
            r_out_vld <= 1'b1;
        end else if (i_m_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((push_mid && out_free) || push_fin) begin
            r_out_hit  <= r_pend_vld;
            r_out_rule <= r_pend_vld ? 4'(r_pend_rule) : 4'd0;
            r_out_last <= push_fin;
            r_out_time <= cur;
        end
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tuser  = r_out_hit;
    assign o_m_tlast  = r_out_last;
    assign o_m_tdata  = {7'd0, r_out_time.weekday, r_out_time.minute, r_out_time.hour,
                         r_out_time.day, r_out_time.month, r_out_time.year, r_out_rule};

endmodule

// ===== dv/tb_cron_calendar_alarm_matcher.sv =====
// Self-checking testbench for the cron calendar alarm matcher.
`timescale 1ns / 1ps

module tb_cron_calendar_alarm_matcher;
    import cca_pkg::*;

    // Kind code that the block must ignore
    localparam logic [1:0] REQ_UNUSED = 2'd3;
    localparam int RANDOM_ITEMS = 100;
    localparam int CALM_FROM    = 84;
    localparam int STALL_LIMIT  = 3000;
    localparam int TAIL_CYCLES  = 40;

    // One alarm result as seen on the master side
    typedef struct {
        logic       hit;
        logic [3:0] rule;
        t_time      stamp;
        logic       last;
    } alarm_result_t;

    // One input item, with an optional typed-in result
    typedef struct {
        logic [1:0]    kind;
        logic [3:0]    slot;
        t_rule         rule;
        t_set          clock_set;
        bit            has_want;
        alarm_result_t want;
    } stim_t;

    logic         i_clk      = 1'b0;
    logic         i_rst_n    = 1'b0;
    logic         i_s_tvalid = 1'b0;
    logic         o_s_tready;
    // rule_index, minute_mask, hour_mask, day_mask, month_mask, weekday_mask,
    // set_year, set_month, set_day, set_hour, set_minute, 4 zero bits
    logic [175:0] i_s_tdata  = '0;
    // req_type
    logic [1:0]   i_s_tuser  = REQ_LOAD;
    logic         o_m_tvalid;
    logic         i_m_tready = 1'b0;
    // matched_rule, out_year, out_month, out_day, out_hour, out_minute,
    // out_weekday, 7 zero bits
    logic [47:0]  o_m_tdata;
    // hit
    logic         o_m_tuser;
    // last
    logic         o_m_tlast;

    // Predictor state
    t_rule         rule_table [RULE_COUNT];
    t_time         clock_now;
    alarm_result_t expected_alarms [$];
    stim_t         directed_rows [$];

    int error_count = 0;
    bit calm        = 1'b0;
    int stall_left  = 0;
    int quiet_cycles = 0;

    cron_calendar_alarm_matcher u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

    // Clock
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Calendar helpers
    function automatic int month_days(int y, int m);
        bit leap;
        leap = (y % 400 == 0) || (y % 4 == 0 && y % 100 != 0);
        case (m)
            2:             return leap ? 29 : 28;
            4, 6, 9, 11:   return 30;
            default:       return 31;
        endcase
    endfunction

    // Days since Thursday 1970-01-01, folded onto the week
    function automatic int weekday_from_date(int y, int m, int d);
        int days;
        days = 365 * (y - 1970) + ((y - 1) / 4 - (y - 1) / 100 + (y - 1) / 400) - 477;
        for (int mm = 1; mm < m; mm++) days += month_days(y, mm);
        days += d - 1;
        return (4 + days) % 7;
    endfunction

    // Predict the results of one accepted item and update the model state
    task automatic predict_alarms(input stim_t s, output alarm_result_t produced[$]);
        alarm_result_t res;
        int yy, mm, dd, hh, mi;
        produced = {};
        case (s.kind)
            REQ_LOAD: rule_table[s.slot] = s.rule;
            REQ_SET: begin
                yy = s.clock_set.year;
                if (yy < 1970) yy = 1970;
                else if (yy > 9999) yy = 9999;
                mm = s.clock_set.month;
                if (mm < 1) mm = 1;
                else if (mm > 12) mm = 12;
                dd = s.clock_set.day;
                if (dd < 1) dd = 1;
                else if (dd > month_days(yy, mm)) dd = month_days(yy, mm);
                hh = (s.clock_set.hour > 23) ? 23 : s.clock_set.hour;
                mi = (s.clock_set.minute > 59) ? 59 : s.clock_set.minute;
                clock_now = {14'(yy), 4'(mm), 5'(dd), 5'(hh), 6'(mi),
                             3'(weekday_from_date(yy, mm, dd))};
            end
            REQ_TICK: begin
                // Scan the table in index order
                for (int i = 0; i < RULE_COUNT; i++) begin
                    if (rule_table[i].minute[clock_now.minute] &&
                        rule_table[i].hour[clock_now.hour] &&
                        rule_table[i].day[clock_now.day - 5'd1] &&
                        rule_table[i].month[clock_now.month - 4'd1] &&
                        rule_table[i].weekday[clock_now.weekday]) begin
                        res.hit   = 1'b1;
                        res.rule  = 4'(i);
                        res.stamp = clock_now;
                        res.last  = 1'b0;
                        produced.insert(produced.size(), res);
                    end
                end
                if (produced.size() == 0) begin
                    res.hit   = 1'b0;
                    res.rule  = 4'd0;
                    res.stamp = clock_now;
                    res.last  = 1'b0;
                    produced.insert(produced.size(), res);
                end
                produced[produced.size() - 1].last = 1'b1;
                // Advance one minute, holding at the end of the calendar
                if (!(clock_now.year == YEAR_MAX && clock_now.month == 4'd12 &&
                      clock_now.day == 5'd31 && clock_now.hour == 5'd23 &&
                      clock_now.minute == 6'd59)) begin
                    if (clock_now.minute != 6'd59) begin
                        clock_now.minute++;
                    end else begin
                        clock_now.minute = 6'd0;
                        if (clock_now.hour != 5'd23) begin
                            clock_now.hour++;
                        end else begin
                            clock_now.hour    = 5'd0;
                            clock_now.weekday = (clock_now.weekday == 3'd6) ? 3'd0
                                                : clock_now.weekday + 3'd1;
                            if (clock_now.day != 5'(month_days(clock_now.year,
                                                               clock_now.month))) begin
                                clock_now.day++;
                            end else begin
                                clock_now.day = 5'd1;
                                if (clock_now.month != 4'd12) begin
                                    clock_now.month++;
                                end else begin
                                    clock_now.month = 4'd1;
                                    clock_now.year++;
                                end
                            end
                        end
                    end
                end
            end
            default: ;
        endcase
    endtask

    // Item of the given kind with random content in every slot, rule and set field
    function automatic stim_t mk_item(logic [1:0] kind);
        stim_t s;
        logic [191:0] noise;
        noise = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        s.kind              = kind;
        s.slot              = noise[3:0];
        s.rule.minute       = noise[63:4];
        s.rule.hour         = noise[87:64];
        s.rule.day          = noise[118:88];
        s.rule.month        = noise[130:119];
        s.rule.weekday      = noise[137:131];
        s.clock_set.year    = noise[151:138];
        s.clock_set.month   = noise[155:152];
        s.clock_set.day     = noise[160:156];
        s.clock_set.hour    = noise[165:161];
        s.clock_set.minute  = noise[171:166];
        s.has_want          = 1'b0;
        s.want              = '{default: '0};
        return s;
    endfunction

    function automatic stim_t mk_load(int slot, logic [59:0] mn, logic [23:0] hr,
                                      logic [30:0] dy, logic [11:0] mo, logic [6:0] wd);
        stim_t s;
        s = mk_item(REQ_LOAD);
        s.slot = 4'(slot);
        s.rule = {mn, hr, dy, mo, wd};
        return s;
    endfunction

    function automatic stim_t mk_set(int y, int m, int d, int h, int mi);
        stim_t s;
        s = mk_item(REQ_SET);
        s.clock_set = {14'(y), 4'(m), 5'(d), 5'(h), 6'(mi)};
        return s;
    endfunction

    // Single-result tick with the result typed in
    function automatic stim_t mk_tick_exp(logic hit, int rule, int y, int m, int d,
                                          int h, int mi, int wd);
        stim_t s;
        s = mk_item(REQ_TICK);
        s.has_want   = 1'b1;
        s.want.hit   = hit;
        s.want.rule  = 4'(rule);
        s.want.stamp = {14'(y), 4'(m), 5'(d), 5'(h), 6'(mi), 3'(wd)};
        s.want.last  = 1'b1;
        return s;
    endfunction

    // Append one row to the directed table
    task automatic add_row(input stim_t s);
        directed_rows.insert(directed_rows.size(), s);
    endtask

    // Random mask, biased toward hitting the bit of the current time
    function automatic logic [63:0] pick_mask(int width, int hit_bit);
        logic [63:0] full, rnd;
        full = (64'd1 << width) - 64'd1;
        rnd  = {$urandom, $urandom} & full;
        case ($urandom_range(0, 3))
            0:       return full;
            1:       return rnd;
            2:       return 64'd1 << hit_bit;
            default: return rnd | (64'd1 << hit_bit);
        endcase
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("%0t ns: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
        error_count++;
    endtask

    // Send one item, with an optional idle burst before it
    task automatic send_item(input stim_t s);
        alarm_result_t produced [$];
        if (!calm && $urandom_range(0, 3) == 0) begin
            i_s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= s.kind;
        i_s_tdata  <= {4'b0, s.clock_set.minute, s.clock_set.hour, s.clock_set.day,
                       s.clock_set.month, s.clock_set.year, s.rule.weekday, s.rule.month,
                       s.rule.day, s.rule.hour, s.rule.minute, s.slot};
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        predict_alarms(s, produced);
        if (s.has_want) expected_alarms.insert(expected_alarms.size(), s.want);
        else foreach (produced[k]) expected_alarms.insert(expected_alarms.size(), produced[k]);
    endtask

    // Hold off the sender until every expected result has come
    task automatic drain_alarms();
        i_s_tvalid <= 1'b0;
        do @(posedge i_clk); while (expected_alarms.size() != 0);
    endtask

    // Receiver with random stall bursts
    always @(posedge i_clk) begin
        if (calm) begin
            i_m_tready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            i_m_tready <= 1'b0;
        end else if ($urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 18);
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= 1'b1;
        end
    end

    // Result checker
    always @(posedge i_clk) begin
        alarm_result_t got, want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got.hit           = o_m_tuser;
            got.rule          = o_m_tdata[3:0];
            got.stamp.year    = o_m_tdata[17:4];
            got.stamp.month   = o_m_tdata[21:18];
            got.stamp.day     = o_m_tdata[26:22];
            got.stamp.hour    = o_m_tdata[31:27];
            got.stamp.minute  = o_m_tdata[37:32];
            got.stamp.weekday = o_m_tdata[40:38];
            got.last          = o_m_tlast;
            if (expected_alarms.size() == 0) begin
                report_mismatch("result with nothing expected, rule", got.rule, -1);
            end else begin
                want = expected_alarms.pop_front();
                if (got.hit != want.hit) report_mismatch("hit", got.hit, want.hit);
                if (got.rule != want.rule) report_mismatch("matched_rule", got.rule, want.rule);
                if (got.stamp.year != want.stamp.year)
                    report_mismatch("out_year", got.stamp.year, want.stamp.year);
                if (got.stamp.month != want.stamp.month)
                    report_mismatch("out_month", got.stamp.month, want.stamp.month);
                if (got.stamp.day != want.stamp.day)
                    report_mismatch("out_day", got.stamp.day, want.stamp.day);
                if (got.stamp.hour != want.stamp.hour)
                    report_mismatch("out_hour", got.stamp.hour, want.stamp.hour);
                if (got.stamp.minute != want.stamp.minute)
                    report_mismatch("out_minute", got.stamp.minute, want.stamp.minute);
                if (got.stamp.weekday != want.stamp.weekday)
                    report_mismatch("out_weekday", got.stamp.weekday, want.stamp.weekday);
                if (got.last != want.last) report_mismatch("last", got.last, want.last);
            end
        end
    end

    // Watchdog on cycles with no item moving on either side
    initial begin
        forever begin
            @(posedge i_clk);
            if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) quiet_cycles = 0;
            else quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    // Main sequence
    initial begin
        stim_t s;
        int pick;
        int yy, mm;
        logic [63:0] m64;

        foreach (rule_table[i]) rule_table[i] = '0;
        clock_now = {YEAR_MIN, 4'd1, 5'd1, 5'd0, 6'd0, 3'd4};

        // Directed rows: reset state, full and empty masks, saturation, calendar edges
        add_row(mk_tick_exp(1'b0, 0, 1970, 1, 1, 0, 0, 4));
        add_row(mk_load(0, '1, '1, '1, '1, '1));
        add_row(mk_load(15, '1, '1, '1, '1, '1));
        add_row(mk_item(REQ_TICK));
        add_row(mk_set(0, 0, 0, 31, 63));
        add_row(mk_item(REQ_TICK));
        add_row(mk_item(REQ_TICK));
        add_row(mk_load(15, '0, '0, '0, '0, '0));
        add_row(mk_set(16383, 15, 31, 31, 63));
        add_row(mk_load(0, '0, '0, '0, '0, '0));
        add_row(mk_tick_exp(1'b0, 0, 9999, 12, 31, 23, 59, 5));
        add_row(mk_tick_exp(1'b0, 0, 9999, 12, 31, 23, 59, 5));
        add_row(mk_item(REQ_UNUSED));
        add_row(mk_set(2000, 2, 31, 12, 30));
        add_row(mk_load(7, 60'd1 << 30, 24'd1 << 12, 31'd1 << 28,
                        12'd1 << 1, 7'd1 << 2));
        add_row(mk_item(REQ_TICK));
        add_row(mk_item(REQ_TICK));
        add_row(mk_set(2100, 2, 30, 23, 59));
        add_row(mk_load(3, '1, '1, '1, '1, '1));
        add_row(mk_item(REQ_TICK));
        add_row(mk_set(2024, 12, 31, 23, 59));
        add_row(mk_item(REQ_TICK));
        add_row(mk_item(REQ_TICK));

        // Reset
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[r]) send_item(directed_rows[r]);
        drain_alarms();

        // Random part
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            calm = (n >= CALM_FROM);
            pick = $urandom_range(0, 99);
            if (pick < 45) begin
                s = mk_item(REQ_TICK);
            end else if (pick < 70) begin
                s = mk_item(REQ_LOAD);
                m64 = pick_mask(60, (clock_now.minute + $urandom_range(0, 2)) % 60);
                s.rule.minute = m64[59:0];
                m64 = pick_mask(24, (clock_now.hour + $urandom_range(0, 1)) % 24);
                s.rule.hour = m64[23:0];
                m64 = pick_mask(31, (clock_now.day - 1 + $urandom_range(0, 1)) % 31);
                s.rule.day = m64[30:0];
                m64 = pick_mask(12, clock_now.month - 1);
                s.rule.month = m64[11:0];
                m64 = pick_mask(7, (clock_now.weekday + $urandom_range(0, 1)) % 7);
                s.rule.weekday = m64[6:0];
            end else if (pick < 92) begin
                s = mk_item(REQ_SET);
                // Mostly in range and near rollovers; otherwise raw noise
                if ($urandom_range(0, 3) != 0) begin
                    case ($urandom_range(0, 3))
                        0:       yy = 1970;
                        1:       yy = 9999;
                        default: yy = $urandom_range(1970, 9999);
                    endcase
                    mm = $urandom_range(1, 12);
                    s.clock_set.year   = 14'(yy);
                    s.clock_set.month  = 4'(mm);
                    s.clock_set.day    = $urandom_range(0, 1) ? 5'(month_days(yy, mm))
                                         : 5'($urandom_range(1, month_days(yy, mm)));
                    s.clock_set.hour   = $urandom_range(0, 1) ? 5'd23 : 5'($urandom_range(0, 23));
                    s.clock_set.minute = $urandom_range(0, 1) ? 6'd59 : 6'($urandom_range(0, 59));
                end
            end else begin
                s = mk_item(REQ_UNUSED);
            end
            send_item(s);
            if (n == RANDOM_ITEMS / 2) drain_alarms();
        end

        // Wind down
        drain_alarms();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
